@@ hdl/srit_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// srit_pkg
// Shared constants and types for the segment / rectangle intersection test.
// ---------------------------------------------------------------------------
package srit_pkg;

    // Default coordinate width (signed Q12.4 at 16 bits).
    localparam int COORD_BITS_DEF = 16;

    // Query kinds carried on the input tuser.
    localparam logic CMD_SEG_SEG  = 1'b0;
    localparam logic CMD_SEG_RECT = 1'b1;

    // Load enables of the pipeline stages, handed to every sub-block.
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en_out;
    } srit_en_t;

endpackage
`default_nettype wire

@@ hdl/srit_prep.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// srit_prep
// First stage: sign-extends the points and builds the two test segments of
// each lane, including the rectangle diagonals in rectangle mode.
// ---------------------------------------------------------------------------
module srit_prep #(
    parameter int COORD_BITS = srit_pkg::COORD_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire srit_pkg::srit_en_t      en,
    input  wire logic                    cmd,
    input  wire logic [COORD_BITS-1:0]   a_x,
    input  wire logic [COORD_BITS-1:0]   a_y,
    input  wire logic [COORD_BITS-1:0]   b_x,
    input  wire logic [COORD_BITS-1:0]   b_y,
    input  wire logic [COORD_BITS-1:0]   c_x,
    input  wire logic [COORD_BITS-1:0]   c_y,
    input  wire logic [COORD_BITS-1:0]   d_x,
    input  wire logic [COORD_BITS-1:0]   d_y,
    output logic                         cmd_reg,
    output logic signed [COORD_BITS:0]   a_x_reg,
    output logic signed [COORD_BITS:0]   a_y_reg,
    output logic signed [COORD_BITS:0]   b_x_reg,
    output logic signed [COORD_BITS:0]   b_y_reg,
    output logic signed [COORD_BITS:0]   c0_x_reg,
    output logic signed [COORD_BITS:0]   c0_y_reg,
    output logic signed [COORD_BITS:0]   d0_x_reg,
    output logic signed [COORD_BITS:0]   d0_y_reg,
    output logic signed [COORD_BITS:0]   c1_x_reg,
    output logic signed [COORD_BITS:0]   c1_y_reg,
    output logic signed [COORD_BITS:0]   d1_x_reg,
    output logic signed [COORD_BITS:0]   d1_y_reg
);
    import srit_pkg::*;

    localparam int P = COORD_BITS + 1;

    logic signed [P-1:0] cx_e, cy_e, dx_e, dy_e, far_x, far_y;
    logic signed [P-1:0] d0_x_next, d0_y_next, c1_y_next, d1_x_next;

    always_comb begin
        cx_e  = {c_x[COORD_BITS-1], c_x};
        cy_e  = {c_y[COORD_BITS-1], c_y};
        dx_e  = {d_x[COORD_BITS-1], d_x};
        dy_e  = {d_y[COORD_BITS-1], d_y};
        // One extra bit keeps origin plus size exact.
        far_x = cx_e + dx_e;
        far_y = cy_e + dy_e;
        if (cmd == CMD_SEG_RECT) begin
            d0_x_next = far_x;
            d0_y_next = far_y;
        end else begin
            d0_x_next = dx_e;
            d0_y_next = dy_e;
        end
        // Second diagonal runs from the top-left to the bottom-right corner.
        c1_y_next = far_y;
        d1_x_next = far_x;
    end

    always_ff @(posedge aclk) begin
        if (en.en1) begin
            cmd_reg  <= cmd;
            a_x_reg  <= {a_x[COORD_BITS-1], a_x};
            a_y_reg  <= {a_y[COORD_BITS-1], a_y};
            b_x_reg  <= {b_x[COORD_BITS-1], b_x};
            b_y_reg  <= {b_y[COORD_BITS-1], b_y};
            c0_x_reg <= cx_e;
            c0_y_reg <= cy_e;
            d0_x_reg <= d0_x_next;
            d0_y_reg <= d0_y_next;
            c1_x_reg <= cx_e;
            c1_y_reg <= c1_y_next;
            d1_x_reg <= d1_x_next;
            d1_y_reg <= cy_e;
        end
    end

endmodule
`default_nettype wire

@@ hdl/srit_lane.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// srit_lane
// One segment against segment test: box and endpoint compares with the
// coordinate differences, then the eight products, then the orientation
// signs and the hit decision.
// ---------------------------------------------------------------------------
module srit_lane #(
    parameter int COORD_BITS = srit_pkg::COORD_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire srit_pkg::srit_en_t      en,
    input  wire logic signed [COORD_BITS:0] a_x,
    input  wire logic signed [COORD_BITS:0] a_y,
    input  wire logic signed [COORD_BITS:0] b_x,
    input  wire logic signed [COORD_BITS:0] b_y,
    input  wire logic signed [COORD_BITS:0] c_x,
    input  wire logic signed [COORD_BITS:0] c_y,
    input  wire logic signed [COORD_BITS:0] d_x,
    input  wire logic signed [COORD_BITS:0] d_y,
    output logic                         hit
);
    import srit_pkg::*;

    localparam int P = COORD_BITS + 1;
    localparam int D = COORD_BITS + 2;
    localparam int M = 2 * D;
    localparam int S = M + 1;

    // Stage two: differences and compares.
    logic signed [D-1:0] acx_reg, acy_reg, bcx_reg, bcy_reg, dcx_reg, dcy_reg;
    logic signed [D-1:0] cax_reg, cay_reg, dax_reg, day_reg, bax_reg, bay_reg;
    logic box_reg, a_in_reg, b_in_reg, c_in_reg, d_in_reg;
    logic box_next, a_in_next, b_in_next, c_in_next, d_in_next;
    logic signed [P-1:0] abx_lo, abx_hi, aby_lo, aby_hi;
    logic signed [P-1:0] cdx_lo, cdx_hi, cdy_lo, cdy_hi;

    // Stage three: products.
    logic signed [M-1:0] p1u_reg, p1v_reg, p2u_reg, p2v_reg;
    logic signed [M-1:0] p3u_reg, p3v_reg, p4u_reg, p4v_reg;
    logic box3_reg, a_in3_reg, b_in3_reg, c_in3_reg, d_in3_reg;

    // Output logic.
    logic signed [S-1:0] o1, o2, o3, o4;
    logic n1, n2, n3, n4, z1, z2, z3, z4, q1, q2, q3, q4;

    always_comb begin
        abx_lo = (a_x < b_x) ? a_x : b_x;
        abx_hi = (a_x > b_x) ? a_x : b_x;
        aby_lo = (a_y < b_y) ? a_y : b_y;
        aby_hi = (a_y > b_y) ? a_y : b_y;
        cdx_lo = (c_x < d_x) ? c_x : d_x;
        cdx_hi = (c_x > d_x) ? c_x : d_x;
        cdy_lo = (c_y < d_y) ? c_y : d_y;
        cdy_hi = (c_y > d_y) ? c_y : d_y;
        box_next  = !(abx_hi < cdx_lo || cdx_hi < abx_lo ||
                      aby_hi < cdy_lo || cdy_hi < aby_lo);
        a_in_next = a_x >= cdx_lo && a_x <= cdx_hi && a_y >= cdy_lo && a_y <= cdy_hi;
        b_in_next = b_x >= cdx_lo && b_x <= cdx_hi && b_y >= cdy_lo && b_y <= cdy_hi;
        c_in_next = c_x >= abx_lo && c_x <= abx_hi && c_y >= aby_lo && c_y <= aby_hi;
        d_in_next = d_x >= abx_lo && d_x <= abx_hi && d_y >= aby_lo && d_y <= aby_hi;
    end

    always_ff @(posedge aclk) begin
        if (en.en2) begin
            acx_reg  <= D'(a_x) - D'(c_x);
            acy_reg  <= D'(a_y) - D'(c_y);
            bcx_reg  <= D'(b_x) - D'(c_x);
            bcy_reg  <= D'(b_y) - D'(c_y);
            dcx_reg  <= D'(d_x) - D'(c_x);
            dcy_reg  <= D'(d_y) - D'(c_y);
            cax_reg  <= D'(c_x) - D'(a_x);
            cay_reg  <= D'(c_y) - D'(a_y);
            dax_reg  <= D'(d_x) - D'(a_x);
            day_reg  <= D'(d_y) - D'(a_y);
            bax_reg  <= D'(b_x) - D'(a_x);
            bay_reg  <= D'(b_y) - D'(a_y);
            box_reg  <= box_next;
            a_in_reg <= a_in_next;
            b_in_reg <= b_in_next;
            c_in_reg <= c_in_next;
            d_in_reg <= d_in_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.en3) begin
            p1u_reg   <= M'(acx_reg) * M'(dcy_reg);
            p1v_reg   <= M'(dcx_reg) * M'(acy_reg);
            p2u_reg   <= M'(bcx_reg) * M'(dcy_reg);
            p2v_reg   <= M'(dcx_reg) * M'(bcy_reg);
            p3u_reg   <= M'(cax_reg) * M'(bay_reg);
            p3v_reg   <= M'(bax_reg) * M'(cay_reg);
            p4u_reg   <= M'(dax_reg) * M'(bay_reg);
            p4v_reg   <= M'(bax_reg) * M'(day_reg);
            box3_reg  <= box_reg;
            a_in3_reg <= a_in_reg;
            b_in3_reg <= b_in_reg;
            c_in3_reg <= c_in_reg;
            d_in3_reg <= d_in_reg;
        end
    end

    always_comb begin
        o1 = S'(p1u_reg) - S'(p1v_reg);
        o2 = S'(p2u_reg) - S'(p2v_reg);
        o3 = S'(p3u_reg) - S'(p3v_reg);
        o4 = S'(p4u_reg) - S'(p4v_reg);
        n1 = o1[S-1];
        n2 = o2[S-1];
        n3 = o3[S-1];
        n4 = o4[S-1];
        z1 = (o1 == '0);
        z2 = (o2 == '0);
        z3 = (o3 == '0);
        z4 = (o4 == '0);
        q1 = !n1 && !z1;
        q2 = !n2 && !z2;
        q3 = !n3 && !z3;
        q4 = !n4 && !z4;
        // A strict straddle needs opposite signs on both pairs; a zero product
        // means a collinear endpoint, which hits when it lies on the other span.
        hit = box3_reg && (
                  (((n1 && q2) || (q1 && n2)) && ((n3 && q4) || (q3 && n4))) ||
                  (z1 && a_in3_reg) || (z2 && b_in3_reg) ||
                  (z3 && c_in3_reg) || (z4 && d_in3_reg));
    end

endmodule
`default_nettype wire

@@ hdl/segment_rect_intersect_test_unit.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// segment_rect_intersect_test_unit
// Collision query pipeline: segment against segment, or segment against an
// axis-aligned rectangle, one hit flag per query.
// ---------------------------------------------------------------------------
//  Channel  Direction  Word contents
//  s_       in         tuser: cmd; tdata: a_x a_y b_x b_y c_x c_y d_x d_y
//  m_       out        tdata: hit (bit 0, zero padded to a byte)
//
//  A query passes four register stages: point preparation, differences and
//  box compares, products, then orientation signs into the output register.
//  A new query is taken in every cycle while s_tready is high, which it
//  is unless the pipeline is full and the output word is held.
//  Each stage loads when it is empty or its successor loads, so bubbles
//  close up and the input keeps flowing while an output word waits, until
//  all four stages are full.
//  Reset (aresetn low, synchronous) clears the stage valid bits only.
// ---------------------------------------------------------------------------
module segment_rect_intersect_test_unit #(
    parameter int COORD_BITS = srit_pkg::COORD_BITS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y from the lowest bit up
    input  wire logic [8*COORD_BITS-1:0]   s_tdata,
    // cmd
    input  wire logic [0:0]                s_tuser,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // hit, then seven zero bits
    output logic [7:0]                     m_tdata
);
    import srit_pkg::*;

    localparam int W = COORD_BITS;
    localparam int P = COORD_BITS + 1;

    srit_en_t en;
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic hit_reg, hit_next;

    logic                cmd1;
    logic signed [P-1:0] a_x1, a_y1, b_x1, b_y1;
    logic signed [P-1:0] c0_x1, c0_y1, d0_x1, d0_y1, c1_x1, c1_y1, d1_x1, d1_y1;
    logic                cmd2_reg, cmd3_reg, con2_reg, con3_reg, con_next;
    logic                hit0, hit1;

    always_comb begin
        en.en_out = !vo_reg || m_tready;
        en.en3    = !v3_reg || en.en_out;
        en.en2    = !v2_reg || en.en3;
        en.en1    = !v1_reg || en.en2;
    end

    assign s_tready = en.en1;
    assign m_tvalid = vo_reg;
    assign m_tdata  = {7'd0, hit_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (en.en1)    v1_reg <= s_tvalid;
            if (en.en2)    v2_reg <= v1_reg;
            if (en.en3)    v3_reg <= v2_reg;
            if (en.en_out) vo_reg <= v3_reg;
        end
    end

    srit_prep #(.COORD_BITS(COORD_BITS)) u_prep (
        .aclk     (aclk),
        .en       (en),
        .cmd      (s_tuser[0]),
        .a_x      (s_tdata[0*W +: W]),
        .a_y      (s_tdata[1*W +: W]),
        .b_x      (s_tdata[2*W +: W]),
        .b_y      (s_tdata[3*W +: W]),
        .c_x      (s_tdata[4*W +: W]),
        .c_y      (s_tdata[5*W +: W]),
        .d_x      (s_tdata[6*W +: W]),
        .d_y      (s_tdata[7*W +: W]),
        .cmd_reg  (cmd1),
        .a_x_reg  (a_x1),
        .a_y_reg  (a_y1),
        .b_x_reg  (b_x1),
        .b_y_reg  (b_y1),
        .c0_x_reg (c0_x1),
        .c0_y_reg (c0_y1),
        .d0_x_reg (d0_x1),
        .d0_y_reg (d0_y1),
        .c1_x_reg (c1_x1),
        .c1_y_reg (c1_y1),
        .d1_x_reg (d1_x1),
        .d1_y_reg (d1_y1)
    );

    // Lane 0 tests the second segment, or the first rectangle diagonal.
    srit_lane #(.COORD_BITS(COORD_BITS)) u_lane0 (
        .aclk (aclk), .en (en),
        .a_x (a_x1), .a_y (a_y1), .b_x (b_x1), .b_y (b_y1),
        .c_x (c0_x1), .c_y (c0_y1), .d_x (d0_x1), .d_y (d0_y1),
        .hit (hit0)
    );

    // Lane 1 tests the second rectangle diagonal; ignored for two segments.
    srit_lane #(.COORD_BITS(COORD_BITS)) u_lane1 (
        .aclk (aclk), .en (en),
        .a_x (a_x1), .a_y (a_y1), .b_x (b_x1), .b_y (b_y1),
        .c_x (c1_x1), .c_y (c1_y1), .d_x (d1_x1), .d_y (d1_y1),
        .hit (hit1)
    );

    // In rectangle mode lane 0 holds the origin and the far corner.
    always_comb begin
        con_next = (a_x1 >= c0_x1 && a_x1 <= d0_x1 && a_y1 >= c0_y1 && a_y1 <= d0_y1) ||
                   (b_x1 >= c0_x1 && b_x1 <= d0_x1 && b_y1 >= c0_y1 && b_y1 <= d0_y1);
        if (cmd3_reg == CMD_SEG_RECT) begin
            hit_next = con3_reg || hit0 || hit1;
        end else begin
            hit_next = hit0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.en2) begin
            cmd2_reg <= cmd1;
            con2_reg <= con_next;
        end
        if (en.en3) begin
            cmd3_reg <= cmd2_reg;
            con3_reg <= con2_reg;
        end
        if (en.en_out) begin
            hit_reg <= hit_next;
        end
    end

    // The input can only be held off by a full pipeline stalled at the output.
    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

    // An accepted word always lands in the first stage.
    a_accept_fills_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted word lost at first stage");

    // A finished word moves to the output whenever the output register frees.
    a_last_stage_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && en.en_out) |=> m_tvalid)
        else $error("finished word did not reach the output");

endmodule
`default_nettype wire
